### design/fca_pkg.sv
// package: request/result types, operation and status codes for the chain allocator
`timescale 1ns / 1ps
package fca_pkg;

  // table entry codes
  localparam logic [15:0] END_MARK = 16'hFFFF;
  localparam logic [15:0] FREE_MARK = 16'h0000;

  // operation codes
  localparam logic [1:0] FUNC_EXTEND = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_FREE   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BROKEN  = 2'd2;

  localparam int POS_W = 24;

  typedef struct packed {
    logic [1:0]       func;
    logic [15:0]      chain_start;
    logic [POS_W-1:0] byte_position;
  } fca_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block;
    logic [15:0] chain_length;
  } fca_out_t;

  // what the table walker is doing between read and check
  typedef enum logic [4:0] {
    MODE_WALK       = 5'b00001,
    MODE_SCAN_FIRST = 5'b00010,
    MODE_SCAN       = 5'b00100,
    MODE_LOOK       = 5'b01000,
    MODE_FREE       = 5'b10000
  } fca_mode_t;

endpackage

### design/fca_div.sv
// divider of the byte position by the constant block size, by reciprocal multiplication
`timescale 1ns / 1ps
module fca_div #(
  parameter int DIVISOR = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fca_pkg::POS_W-1:0] dividend,
  output logic                      done,
  output logic [fca_pkg::POS_W-1:0] quot,
  output logic                      rem_nz
);
  import fca_pkg::*;

  // rounded-up reciprocal and shift, exact for every dividend of POS_W bits
  localparam int SH_L = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int SH = POS_W + SH_L;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [POS_W:0] RECIP = RECIP64[POS_W:0];
  localparam logic [16:0] DIV17 = 17'(DIVISOR);

  logic               run_r, run_nxt;
  logic               step_r, step_nxt;
  logic [POS_W-1:0]   x_r, x_nxt;
  logic [POS_W-1:0]   q_r, q_nxt;
  logic               rnz_r, rnz_nxt;
  logic [2*POS_W:0]   prod;
  logic [POS_W+16:0]  back;

  // step one: quotient by multiply and shift; step two: remainder test
  always_comb begin
    prod     = (2*POS_W+1)'(x_r) * (2*POS_W+1)'(RECIP);
    back     = (POS_W+17)'(q_r) * (POS_W+17)'(DIV17);
    run_nxt  = run_r;
    step_nxt = step_r;
    x_nxt    = x_r;
    q_nxt    = q_r;
    rnz_nxt  = rnz_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = 1'b0;
      x_nxt    = dividend;
    end else if (run_r) begin
      if (!step_r) begin
        q_nxt    = POS_W'(prod >> SH);
        step_nxt = 1'b1;
      end else begin
        rnz_nxt = (back != (POS_W+17)'(x_r));
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      step_r <= step_nxt;
    end
    x_r   <= x_nxt;
    q_r   <= q_nxt;
    rnz_r <= rnz_nxt;
  end

  assign done   = !run_r;
  assign quot   = q_r;
  assign rem_nz = rnz_r;

endmodule

### design/fca_table.sv
// allocation table memory: one write port, one read port with registered data
`timescale 1ns / 1ps
module fca_table #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data
);
  import fca_pkg::*;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/fat_chain_allocator.sv
// top level: allocation table chain allocator sequencer
//
//  channel   ports                      handshake
//  request   start, busy, in_data       taken when start high and busy low
//  result    out_valid, out_data        one cycle strobe, cannot be held off
//
// After reset the table is swept to zero, one entry a cycle, with busy high
// throughout. A request then passes through the divider that turns the byte
// position into blocks, a dispatch state, a read and a check state per table
// access (one read port with registered read data), a link state per block
// hooked onto a chain tail, and a result state.
// One request is worked at a time; the result strobe follows the last access.
`timescale 1ns / 1ps
module fat_chain_allocator #(
  parameter int NUM_BLOCKS = 1024,
  parameter int BLOCK_BYTES = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fca_pkg::fca_in_t  in_data,
  output logic             out_valid,
  output fca_pkg::fca_out_t out_data
);
  import fca_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [16:0] BC17 = 17'(NUM_BLOCKS);
  localparam logic [AW:0] BCP = (AW+1)'(NUM_BLOCKS);

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_DIV  = 8'b00000100,
    S_DISP = 8'b00001000,
    S_RD   = 8'b00010000,
    S_CHK  = 8'b00100000,
    S_LINK = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t      state_r, state_nxt;
  fca_mode_t   mode_r, mode_nxt;
  fca_in_t     req_r, req_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW:0]   ptr_r, ptr_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [15:0] block_r, block_nxt;
  logic [15:0] len_r, len_nxt;

  logic             div_start, div_done, div_rem_nz;
  logic [POS_W-1:0] div_q, need, idx;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [15:0]      rd_data, wr_data;
  logic [16:0]      cnt_inc;
  logic [AW:0]      ptr_inc;

  function automatic logic is_valid(input logic [15:0] b);
    is_valid = ({1'b0, b} < BC17);
  endfunction

  fca_div #(.DIVISOR(BLOCK_BYTES)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(in_data.byte_position),
    .done(div_done), .quot(div_q), .rem_nz(div_rem_nz)
  );

  fca_table #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_table (
    .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  assign idx  = div_q;
  assign need = div_q + POS_W'(div_rem_nz);
  assign cnt_inc = {1'b0, cnt_r} + 17'd1;
  assign ptr_inc = ptr_r + 1'b1;

  // read address: scan pointer while hunting for free blocks, else chain cursor
  assign rd_en   = (state_r == S_RD);
  assign rd_addr = (mode_r == MODE_SCAN || mode_r == MODE_SCAN_FIRST) ?
                   ptr_r[AW-1:0] : cur_r[AW-1:0];

  assign busy      = (state_r != S_IDLE);
  assign div_start = (state_r == S_IDLE) && start;
  assign out_valid = (state_r == S_DONE);
  assign out_data  = '{status: status_r, block: block_r, chain_length: len_r};

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    req_nxt    = req_r;
    clr_nxt    = clr_r;
    ptr_nxt    = ptr_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    status_nxt = status_r;
    block_nxt  = block_r;
    len_nxt    = len_r;
    wr_en      = 1'b0;
    wr_addr    = cur_r[AW-1:0];
    wr_data    = FREE_MARK;
    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        status_nxt = ST_OK;
        block_nxt  = req_r.chain_start;
        len_nxt    = '0;
        cur_nxt    = req_r.chain_start;
        fin_nxt    = 1'b0;
        state_nxt  = S_DONE;
        unique case (req_r.func)
          FUNC_EXTEND: begin
            if (req_r.chain_start == END_MARK) begin
              if (need != '0) begin
                mode_nxt  = MODE_SCAN_FIRST;
                ptr_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = S_RD;
              end
            end else if (!is_valid(req_r.chain_start)) begin
              status_nxt = ST_BROKEN;
            end else begin
              mode_nxt  = MODE_WALK;
              cnt_nxt   = 16'd1;
              state_nxt = S_RD;
            end
          end
          FUNC_LOOKUP: begin
            if (idx >= POS_W'(BC17) || !is_valid(req_r.chain_start)) begin
              status_nxt = ST_BROKEN;
              block_nxt  = END_MARK;
            end else if (idx != '0) begin
              mode_nxt  = MODE_LOOK;
              cnt_nxt   = '0;
              state_nxt = S_RD;
            end
          end
          FUNC_FREE: begin
            cnt_nxt = '0;
            if (req_r.chain_start != END_MARK) begin
              if (!is_valid(req_r.chain_start)) begin
                status_nxt = ST_BROKEN;
              end else begin
                mode_nxt  = MODE_FREE;
                state_nxt = S_RD;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_RD;
        unique case (mode_r)
          MODE_WALK: begin
            if (rd_data == END_MARK) begin
              // chain end reached: append while short of the need
              if (POS_W'(cnt_r) < need) begin
                mode_nxt = MODE_SCAN;
                ptr_nxt  = '0;
              end else begin
                len_nxt   = cnt_r;
                state_nxt = S_DONE;
              end
            end else if (!is_valid(rd_data) || {1'b0, cnt_r} >= BC17) begin
              status_nxt = ST_BROKEN;
              len_nxt    = cnt_r;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt = rd_data;
              cnt_nxt = cnt_inc[15:0];
            end
          end
          MODE_SCAN_FIRST, MODE_SCAN: begin
            if (rd_data == FREE_MARK) begin
              wr_en   = 1'b1;
              wr_addr = ptr_r[AW-1:0];
              wr_data = END_MARK;
              if (mode_r == MODE_SCAN_FIRST) begin
                block_nxt = 16'(ptr_r);
                cur_nxt   = 16'(ptr_r);
                cnt_nxt   = 16'd1;
                mode_nxt  = MODE_SCAN;
                if (POS_W'(1) >= need) begin
                  len_nxt   = 16'd1;
                  state_nxt = S_DONE;
                end else if (ptr_inc >= BCP) begin
                  status_nxt = ST_NO_FREE;
                  len_nxt    = 16'd1;
                  state_nxt  = S_DONE;
                end else begin
                  ptr_nxt = ptr_inc;
                end
              end else begin
                state_nxt = S_LINK;
              end
            end else if (ptr_inc >= BCP) begin
              status_nxt = ST_NO_FREE;
              len_nxt    = cnt_r;
              state_nxt  = S_DONE;
            end else begin
              ptr_nxt = ptr_inc;
            end
          end
          MODE_LOOK: begin
            cur_nxt = rd_data;
            cnt_nxt = cnt_inc[15:0];
            if (!is_valid(rd_data)) begin
              status_nxt = ST_BROKEN;
              block_nxt  = END_MARK;
              state_nxt  = S_DONE;
            end else if (POS_W'(cnt_inc) == idx) begin
              block_nxt = rd_data;
              state_nxt = S_DONE;
            end
          end
          MODE_FREE: begin
            if (fin_r) begin
              // count limit hit: a still linked block means a loop
              if (rd_data != FREE_MARK) begin
                status_nxt = ST_BROKEN;
              end
              len_nxt   = cnt_r;
              state_nxt = S_DONE;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_inc[15:0];
              cur_nxt = rd_data;
              len_nxt = cnt_inc[15:0];
              if (rd_data == END_MARK) begin
                state_nxt = S_DONE;
              end else if (cnt_inc >= BC17) begin
                if (is_valid(rd_data)) begin
                  fin_nxt = 1'b1;
                end else begin
                  state_nxt = S_DONE;
                end
              end else if (!is_valid(rd_data)) begin
                status_nxt = ST_BROKEN;
                state_nxt  = S_DONE;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_LINK: begin
        // hook the new block onto the chain tail
        wr_en   = 1'b1;
        wr_addr = cur_r[AW-1:0];
        wr_data = 16'(ptr_r);
        cur_nxt = 16'(ptr_r);
        cnt_nxt = cnt_inc[15:0];
        if (POS_W'(cnt_inc) >= need) begin
          len_nxt   = cnt_inc[15:0];
          state_nxt = S_DONE;
        end else if (ptr_inc >= BCP) begin
          status_nxt = ST_NO_FREE;
          len_nxt    = cnt_inc[15:0];
          state_nxt  = S_DONE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      mode_r  <= MODE_WALK;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      mode_r  <= mode_nxt;
      fin_r   <= fin_nxt;
    end
    req_r    <= req_nxt;
    ptr_r    <= ptr_nxt;
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    block_r  <= block_nxt;
    len_r    <= len_nxt;
  end

endmodule

### bench/fat_chain_allocator_tb.sv
// testbench: chain allocator checked against a table-tracking scoreboard
`timescale 1ns / 1ps
module fat_chain_allocator_tb;
  import fca_pkg::*;

  localparam int NBLK = 1024;
  localparam int BBYTES = 512;
  localparam longint LIMIT = 40_000_000;

  // scoreboard: own copy of the table, queue of awaited results
  class fca_scoreboard;
    logic [15:0] tbl [NBLK];
    fca_out_t awaited [$];
    int fails;
    int seen;

    function new();
      foreach (tbl[i]) tbl[i] = FREE_MARK;
      fails = 0;
      seen = 0;
    endfunction

    function int unsigned first_free();
      for (int i = 0; i < NBLK; i++)
        if (tbl[i] == FREE_MARK) return i;
      return END_MARK;
    endfunction

    // work out the result of one accepted request and update the table
    function fca_out_t note_request(fca_in_t rq);
      fca_out_t r;
      int unsigned need, cur, cnt, nb, nxt, idx, st;
      bit done;
      st = rq.chain_start;
      r.status = ST_OK;
      r.block = rq.chain_start;
      r.chain_length = 16'd0;
      case (rq.func)
        FUNC_EXTEND: begin
          need = (rq.byte_position + BBYTES - 1) / BBYTES;
          done = 0;
          if (st == END_MARK) begin
            if (need == 0) done = 1;
            else begin
              nb = first_free();
              if (nb == END_MARK) begin
                r.status = ST_NO_FREE;
                done = 1;
              end else begin
                tbl[nb] = END_MARK;
                st = nb;
                r.block = st;
              end
            end
          end
          if (!done && st >= NBLK) begin
            r.status = ST_BROKEN;
            done = 1;
          end
          if (!done) begin
            cur = st;
            cnt = 1;
            while (!done && tbl[cur] != END_MARK) begin
              nxt = tbl[cur];
              if (nxt >= NBLK || cnt >= NBLK) begin
                r.status = ST_BROKEN;
                r.chain_length = cnt[15:0];
                done = 1;
              end else begin
                cur = nxt;
                cnt++;
              end
            end
            if (!done) begin
              while (cnt < need) begin
                nb = first_free();
                if (nb == END_MARK) begin
                  r.status = ST_NO_FREE;
                  break;
                end
                tbl[nb] = END_MARK;
                tbl[cur] = nb[15:0];
                cur = nb;
                cnt++;
              end
              r.chain_length = cnt[15:0];
            end
          end
        end
        FUNC_LOOKUP: begin
          idx = rq.byte_position / BBYTES;
          r.status = ST_BROKEN;
          r.block = END_MARK;
          cur = st;
          done = (idx >= NBLK || cur >= NBLK);
          for (int i = 0; !done && i < idx; i++) begin
            cur = tbl[cur];
            if (cur >= NBLK) done = 1;
          end
          if (!done) begin
            r.status = ST_OK;
            r.block = cur[15:0];
          end
        end
        FUNC_FREE: begin
          cur = st;
          cnt = 0;
          if (cur != END_MARK) begin
            while (cnt < NBLK) begin
              if (cur >= NBLK) begin
                r.status = ST_BROKEN;
                break;
              end
              nxt = tbl[cur];
              tbl[cur] = FREE_MARK;
              cnt++;
              if (nxt == END_MARK) break;
              cur = nxt;
            end
            if (cnt >= NBLK && r.status == ST_OK && cur != END_MARK && cur < NBLK
                && tbl[cur] != FREE_MARK)
              r.status = ST_BROKEN;
            r.chain_length = cnt[15:0];
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
      return r;
    endfunction

    // compare one result strobe with the oldest awaited result
    function void check_result(fca_out_t got);
      fca_out_t exp_r;
      seen++;
      if (awaited.size() == 0) begin
        $error("unexpected result status=%0d block=%0h length=%0d",
               got.status, got.block, got.chain_length);
        fails++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        fails++;
      end
      if (got.block !== exp_r.block) begin
        $error("block: expected %0h, got %0h", exp_r.block, got.block);
        fails++;
      end
      if (got.chain_length !== exp_r.chain_length) begin
        $error("chain_length: expected %0d, got %0d", exp_r.chain_length,
               got.chain_length);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  fca_in_t in_data = '0;
  logic out_valid;
  fca_out_t out_data;

  fca_scoreboard sb;
  longint cycles = 0;
  bit calm = 0;
  int unsigned live [$];
  int n_ext, n_look, n_free, n_other;

  fat_chain_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // issue one request, with random idle cycles ahead of it unless calm is set
  task automatic send_request(input logic [1:0] f, input logic [15:0] cs,
                              input logic [23:0] pos);
    fca_in_t rq;
    fca_out_t r;
    rq.func = f;
    rq.chain_start = cs;
    rq.byte_position = pos;
    @(posedge clk);
    while (!calm && $urandom_range(0, 99) < 28) @(posedge clk);
    start <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    r = sb.note_request(rq);
    case (f)
      FUNC_EXTEND: n_ext++;
      FUNC_LOOKUP: n_look++;
      FUNC_FREE: n_free++;
      default: n_other++;
    endcase
    // keep track of chains that exist, for well-formed follow-ups
    if (f == FUNC_EXTEND && cs == END_MARK && r.block != END_MARK) live.push_back(r.block);
  endtask

  task automatic free_live(input int k);
    int unsigned s;
    s = live[k];
    live.delete(k);
    send_request(FUNC_FREE, s[15:0], 24'd0);
  endtask

  initial begin
    int unsigned pick, s;
    logic [1:0] f;
    sb = new();
    n_ext = 0; n_look = 0; n_free = 0; n_other = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero length, exact and partial blocks, bad starts
    send_request(FUNC_EXTEND, END_MARK, 24'd0);
    send_request(FUNC_EXTEND, END_MARK, 24'd1);
    send_request(FUNC_EXTEND, END_MARK, 24'd512);
    send_request(FUNC_EXTEND, END_MARK, 24'd513);
    send_request(FUNC_EXTEND, live[2][15:0], 24'd2000);
    send_request(FUNC_EXTEND, live[0][15:0], 24'd0);
    send_request(FUNC_LOOKUP, live[2][15:0], 24'd0);
    send_request(FUNC_LOOKUP, live[2][15:0], 24'd1999);
    send_request(FUNC_LOOKUP, live[2][15:0], 24'd2048);
    send_request(FUNC_LOOKUP, END_MARK, 24'd0);
    send_request(FUNC_LOOKUP, 16'd0, 24'hFFFFFF);
    send_request(FUNC_EXTEND, 16'd1024, 24'hFFFFFF);
    send_request(FUNC_EXTEND, 16'hFFFE, 24'hFFFFFF);
    send_request(FUNC_FREE, END_MARK, 24'd0);
    send_request(FUNC_FREE, 16'd2000, 24'd0);
    send_request(FUNC_UNUSED, 16'hA5A5, 24'hFFFFFF);
    free_live(0);

    // directed: run the table out of space, then try again
    send_request(FUNC_EXTEND, END_MARK, 24'(NBLK * BBYTES + 1));
    send_request(FUNC_EXTEND, END_MARK, 24'd100);
    send_request(FUNC_EXTEND, live[0][15:0], 24'd5000);
    send_request(FUNC_LOOKUP, live[live.size()-1][15:0], 24'(900 * BBYTES));
    free_live(live.size() - 1);
    while (live.size() > 0) free_live(0);

    // random traffic, mostly on chains that exist
    for (int n = 0; n < 290; n++) begin
      calm = (n >= 120 && n < 170);
      pick = $urandom_range(0, 99);
      if (pick < 30 || live.size() == 0) begin
        if (live.size() > 0 && $urandom_range(0, 1)) begin
          s = live[$urandom_range(0, live.size() - 1)];
          send_request(FUNC_EXTEND, s[15:0], 24'($urandom_range(0, 6000)));
        end else if ($urandom_range(0, 19) == 0) begin
          send_request(FUNC_EXTEND, END_MARK, 24'($urandom_range(20000, 60000)));
        end else begin
          send_request(FUNC_EXTEND, END_MARK, 24'($urandom_range(0, 4096)));
        end
      end else if (pick < 60) begin
        s = live[$urandom_range(0, live.size() - 1)];
        send_request(FUNC_LOOKUP, s[15:0], 24'($urandom_range(0, 5000)));
      end else if (pick < 80) begin
        free_live($urandom_range(0, live.size() - 1));
      end else if (pick < 88) begin
        send_request(FUNC_LOOKUP, 16'($urandom()), 24'($urandom()));
      end else if (pick < 93) begin
        s = $urandom_range(1024, 65534);
        send_request(pick[0] ? FUNC_EXTEND : FUNC_FREE, s[15:0], 24'($urandom()));
      end else if (pick < 97) begin
        send_request(FUNC_UNUSED, 16'($urandom()), 24'($urandom()));
      end else begin
        // noise on the table: free the chain from an arbitrary in-range block, forget live chains
        f = FUNC_FREE;
        send_request(f, 16'($urandom_range(0, NBLK - 1)), 24'($urandom()));
        live.delete();
      end
    end
    calm = 0;

    // drain, then a margin for anything stray
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (4 * NBLK) @(posedge clk);

    $display("covered %0d extends, %0d lookups, %0d frees, %0d unused codes; %0d results",
             n_ext, n_look, n_free, n_other, sb.seen);
    $display("including out-of-space, broken starts and lookups past chain end");
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
